@@ sv/afs_pkg.sv @@
// Package for the aspect fit size block: mode codes and size defaults.
// No dependencies; every other file of the block imports it.
`default_nettype none

package afs_pkg;

  localparam int unsigned SIZE_BITS_DEF = 16;
  localparam int unsigned MODE_BITS     = 4;
  localparam int unsigned OUT_BITS      = 32;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_RAW    = 4'd0,
    MODE_BOX    = 4'd1,
    MODE_WIDTH  = 4'd2,
    MODE_HEIGHT = 4'd3,
    MODE_INNER  = 4'd4,
    MODE_OUTER  = 4'd5,
    MODE_WLIMIT = 4'd6,
    MODE_HLIMIT = 4'd7,
    MODE_LIMIT  = 4'd8
  } mode_e;

endpackage

`default_nettype wire

@@ sv/afs_in_if.sv @@
// Request channel of the aspect fit size block: mode, source and box size.
// Depends on afs_pkg for the default size width and the mode field width.
`default_nettype none

interface afs_in_if #(
  parameter int unsigned SIZE_BITS = afs_pkg::SIZE_BITS_DEF
);
  import afs_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [MODE_BITS-1:0]        mode;
  logic signed [SIZE_BITS-1:0] src_w;
  logic signed [SIZE_BITS-1:0] src_h;
  logic signed [SIZE_BITS-1:0] box_w;
  logic signed [SIZE_BITS-1:0] box_h;

  modport source (output valid, mode, src_w, src_h, box_w, box_h, input ready);
  modport sink   (input valid, mode, src_w, src_h, box_w, box_h, output ready);

endinterface

`default_nettype wire

@@ sv/afs_out_if.sv @@
// Result channel of the aspect fit size block: scaled size and divide flag.
// Depends on afs_pkg for the result width.
`default_nettype none

interface afs_out_if;
  import afs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] out_w;
  logic signed [OUT_BITS-1:0] out_h;
  logic                       zero_divide;

  modport source (output valid, out_w, out_h, zero_divide, input ready);
  modport sink   (input valid, out_w, out_h, zero_divide, output ready);

endinterface

`default_nettype wire

@@ sv/aspect_fit_size.sv @@
// Aspect fit size: scales a source size against a box under one of nine modes.
// Requests arrive on in_i (afs_in_if), results leave on out_o (afs_out_if);
// a transfer happens at a rising edge of clk_i with valid and ready both high.
// Every request gives exactly one result, in request order.
// A request passes these stages on its way to out_o: one stage registers it and
// adjusts the box signs, one forms the two cross products, one picks the
// mode's path, SIZE_BITS stages run a restoring divider at two quotient bits
// per stage, and one stage applies the sign and saturates to 32 bits.
// Throughput is one request per cycle while out_o takes results or a stage
// is still empty.
// Each stage carries its own valid bit and holds only when it is full and the
// stage after it holds, so empty stages fill while out_o is stalled and the
// request side keeps taking transfers until every stage is occupied.
// A result waiting on out_o stays unchanged until it is taken.
// rst_ni (asynchronous, active low) empties the pipeline; nothing else is kept.
// A zero divisor on the chosen path gives zero sizes with zero_divide set.
`default_nettype none

module aspect_fit_size #(
  parameter int unsigned SIZE_BITS = afs_pkg::SIZE_BITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  afs_in_if.sink     in_i,
  afs_out_if.source  out_o
);
  import afs_pkg::*;

  localparam int unsigned S    = SIZE_BITS;
  localparam int unsigned PW   = 2 * S + 1;              // cross product width
  localparam int unsigned NDIV = S;                      // two quotient bits a stage
  localparam int unsigned NST  = NDIV + 4;               // total register stages
  localparam int unsigned XW   = (PW > OUT_BITS + 1) ? PW : OUT_BITS + 1;
  localparam int unsigned ST_C = 2;                      // path select stage index

  typedef struct packed {
    logic signed [S:0] pass_w;
    logic signed [S:0] pass_h;
    logic              use_q;
    logic              q_on_h;
    logic              zd;
    logic              neg;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [S-1:0]      rem;
    logic [2*S-1:0]    num;
    logic [S-1:0]      dvs;
  } div_t;

  function automatic div_t div_bit(input div_t x);
    logic [S:0] r;
    div_t       y;
    y     = x;
    r     = {x.rem, x.num[2*S-1]};
    y.num = {x.num[2*S-2:0], 1'b0};
    if (r >= {1'b0, x.dvs}) begin
      r        = r - {1'b0, x.dvs};
      y.num[0] = 1'b1;
    end
    y.rem = r[S-1:0];
    return y;
  endfunction

  function automatic logic [OUT_BITS-1:0] sat32(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    hi = $signed({{(XW - OUT_BITS + 1){1'b0}}, {(OUT_BITS - 1){1'b1}}});
    lo = $signed({{(XW - OUT_BITS + 1){1'b1}}, {(OUT_BITS - 1){1'b0}}});
    if (v > hi) begin
      return hi[OUT_BITS-1:0];
    end else if (v < lo) begin
      return lo[OUT_BITS-1:0];
    end else begin
      return v[OUT_BITS-1:0];
    end
  endfunction

  // Stage valid bits and per-stage advance enables.
  logic [NST-1:0] v_q;
  logic [NST-1:0] v_d;
  logic [NST-1:0] en;

  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = out_o.ready | ~(&v_q[NST-1:k]);
  end

  always_comb begin
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_i.valid;
    end
    for (int unsigned k = 1; k < NST; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_i.ready = en[0];

  // Stage A: register the request; inner and outer modes flip the box sign
  // wherever the matching source component is negative.
  logic [MODE_BITS-1:0] a_mode_q;
  logic signed [S:0]    a_sw_q, a_sh_q, a_bw_q, a_bh_q;
  logic signed [S:0]    a_bw_d, a_bh_d;
  logic                 a_flip;

  always_comb begin
    a_flip = (in_i.mode == MODE_INNER) || (in_i.mode == MODE_OUTER);
    a_bw_d = (S+1)'(in_i.box_w);
    a_bh_d = (S+1)'(in_i.box_h);
    if (a_flip && in_i.src_w[S-1]) begin
      a_bw_d = -a_bw_d;
    end
    if (a_flip && in_i.src_h[S-1]) begin
      a_bh_d = -a_bh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_mode_q <= in_i.mode;
      a_sw_q   <= (S+1)'(in_i.src_w);
      a_sh_q   <= (S+1)'(in_i.src_h);
      a_bw_q   <= a_bw_d;
      a_bh_q   <= a_bh_d;
    end
  end

  // Stage B: the two cross products.
  logic [MODE_BITS-1:0] b_mode_q;
  logic signed [S:0]    b_sw_q, b_sh_q, b_bw_q, b_bh_q;
  logic signed [PW-1:0] b_hw_q, b_wh_q;
  logic signed [PW-1:0] b_hw_d, b_wh_d;

  assign b_hw_d = a_sh_q * a_bw_q;
  assign b_wh_d = a_sw_q * a_bh_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b_mode_q <= a_mode_q;
      b_sw_q   <= a_sw_q;
      b_sh_q   <= a_sh_q;
      b_bw_q   <= a_bw_q;
      b_bh_q   <= a_bh_q;
      b_hw_q   <= b_hw_d;
      b_wh_q   <= b_wh_d;
    end
  end

  // Stage C: choose the path and set up the divider operands.
  div_t                 st_q [NDIV+1];
  div_t                 c_d;
  logic signed [PW-1:0] c_lhs, c_rhs, c_num;
  logic signed [S:0]    c_dv;
  logic                 c_scale, c_by_w;

  always_comb begin
    c_lhs = b_wh_q;
    c_rhs = b_hw_q;
    if (b_bw_q[S] != b_bh_q[S]) begin
      c_lhs = b_hw_q;
      c_rhs = b_wh_q;
    end
    c_d     = '0;
    c_scale = 1'b0;
    c_by_w  = 1'b0;
    c_num   = b_hw_q;
    c_dv    = b_sw_q;
    unique case (b_mode_q) inside
      MODE_RAW: begin
        c_d.side.pass_w = b_sw_q;
        c_d.side.pass_h = b_sh_q;
      end
      MODE_BOX: begin
        c_d.side.pass_w = b_bw_q;
        c_d.side.pass_h = b_bh_q;
      end
      MODE_WIDTH: begin
        c_scale = 1'b1;
        c_by_w  = 1'b1;
      end
      MODE_HEIGHT: begin
        c_scale = 1'b1;
      end
      MODE_INNER, MODE_OUTER: begin
        if (b_bw_q == '0 || b_bh_q == '0) begin
          c_d.side.zd = 1'b1;
        end else begin
          c_scale = 1'b1;
          c_by_w  = (b_mode_q == MODE_INNER) ? (c_lhs > c_rhs) : (c_lhs < c_rhs);
        end
      end
      MODE_WLIMIT, MODE_HLIMIT, MODE_LIMIT: begin
        c_by_w = (b_mode_q == MODE_WLIMIT) ||
                 ((b_mode_q == MODE_LIMIT) && (b_sw_q > b_sh_q));
        if (c_by_w ? (b_sw_q < b_bw_q) : (b_sh_q < b_bh_q)) begin
          c_d.side.pass_w = b_sw_q;
          c_d.side.pass_h = b_sh_q;
        end else begin
          c_scale = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (c_scale) begin
      if (c_by_w) begin
        c_num           = b_hw_q;
        c_dv            = b_sw_q;
        c_d.side.pass_w = b_bw_q;
        c_d.side.q_on_h = 1'b1;
      end else begin
        c_num           = b_wh_q;
        c_dv            = b_sh_q;
        c_d.side.pass_h = b_bh_q;
        c_d.side.q_on_h = 1'b0;
      end
      if (c_dv == '0) begin
        c_d.side.zd     = 1'b1;
        c_d.side.pass_w = '0;
        c_d.side.pass_h = '0;
      end else begin
        c_d.side.use_q = 1'b1;
      end
    end

    c_d.side.neg = c_num[PW-1] ^ c_dv[S];
    c_d.num      = c_num[PW-1] ? (2*S)'(-c_num) : (2*S)'(c_num);
    c_d.dvs      = c_dv[S] ? S'(-c_dv) : S'(c_dv);
    c_d.rem      = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_C]) begin
      st_q[0] <= c_d;
    end
  end

  // Restoring divider, two quotient bits per stage.
  for (genvar j = 1; j <= NDIV; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en[ST_C + j]) begin
        st_q[j] <= div_bit(div_bit(st_q[j-1]));
      end
    end
  end

  // Output stage: sign of the quotient, then saturation to 32 bits.
  logic signed [PW-1:0]       o_q;
  logic signed [XW-1:0]       o_w, o_h;
  side_t                      o_side;
  logic signed [OUT_BITS-1:0] out_w_q, out_h_q;
  logic                       zd_q;

  always_comb begin
    o_side = st_q[NDIV].side;
    o_q    = $signed({1'b0, st_q[NDIV].num});
    if (o_side.neg) begin
      o_q = -o_q;
    end
    o_w = XW'(o_side.pass_w);
    o_h = XW'(o_side.pass_h);
    if (o_side.use_q && o_side.q_on_h) begin
      o_h = XW'(o_q);
    end
    if (o_side.use_q && !o_side.q_on_h) begin
      o_w = XW'(o_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NST-1]) begin
      out_w_q <= sat32(o_w);
      out_h_q <= sat32(o_h);
      zd_q    <= o_side.zd;
    end
  end

  assign out_o.valid       = v_q[NST-1];
  assign out_o.out_w       = out_w_q;
  assign out_o.out_h       = out_h_q;
  assign out_o.zero_divide = zd_q;

  // A zero divisor forces both sizes to zero.
  a_zd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_divide |-> out_o.out_w == '0 && out_o.out_h == '0)
    else $error("zero divide result with non-zero size");

  // The path select never sends a zero divisor into the divider.
  a_div_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_C] && st_q[0].side.use_q |-> st_q[0].dvs != '0 && !st_q[0].side.zd)
    else $error("divider started with a zero divisor");

  // The partial remainder stays below the divisor at the end of the divider.
  a_rem_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_C + NDIV] && st_q[NDIV].side.use_q |-> st_q[NDIV].rem < st_q[NDIV].dvs)
    else $error("divider remainder not below divisor");

  // An accepted request occupies the first stage in the next cycle.
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v_q[0])
    else $error("accepted request lost at the first stage");

  // A full pipeline under stall takes no new request.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !out_o.ready |-> !in_i.ready)
    else $error("request taken while every stage is held");

endmodule

`default_nettype wire

@@ tb/aspect_fit_size_tb.sv @@
// Self-checking testbench for aspect_fit_size: directed and random size requests,
// each result predicted in the scoreboard class below and compared field by field.
// Depends on afs_pkg, afs_in_if, afs_out_if and the aspect_fit_size RTL.
`default_nettype none

module aspect_fit_size_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import afs_pkg::*;

  localparam int unsigned SIZE_BITS = SIZE_BITS_DEF;
  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 11;
  localparam int LATENCY      = SIZE_BITS + 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 240;
  localparam int HOLD_AT      = 120;
  localparam int HOLD_CYCLES  = 250;
  localparam int MAX_REPORTS  = 60;

  localparam logic [MODE_BITS-1:0] MODE_SPARE_LO = 4'd9;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_HI = 4'd15;

  localparam longint SIZE_MAX = (longint'(1) <<< (SIZE_BITS - 1)) - 1;
  localparam longint SIZE_MIN = -SIZE_MAX - 1;
  localparam longint OUT_MAX  = (longint'(1) <<< (OUT_BITS - 1)) - 1;
  localparam longint OUT_MIN  = -OUT_MAX - 1;

  typedef logic signed [SIZE_BITS-1:0] size_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    size_t                src_w;
    size_t                src_h;
    size_t                box_w;
    size_t                box_h;
  } size_req_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] w;
    logic signed [OUT_BITS-1:0] h;
    logic                       zdiv;
  } size_res_t;

  class fit_scoreboard;
    size_res_t expected_sizes[$];
    int        errors;
    int        checked;
    int        zdiv_seen;
    int        mode_hits[16];

    function longint clip_out(longint v);
      if (v > OUT_MAX) return OUT_MAX;
      if (v < OUT_MIN) return OUT_MIN;
      return v;
    endfunction

    // Fixes one side to the box and scales the other; fails on a zero divisor.
    function bit scale_side(bit by_w, longint sw, longint sh, longint bw, longint bh,
                            output longint ow, output longint oh);
      ow = 0;
      oh = 0;
      if (by_w) begin
        if (sw == 0) return 1'b0;
        ow = bw;
        oh = (sh * bw) / sw;
      end else begin
        if (sh == 0) return 1'b0;
        ow = (sw * bh) / sh;
        oh = bh;
      end
      return 1'b1;
    endfunction

    function size_res_t fit_size(size_req_t r);
      longint    sw, sh, bw, bh, ow, oh, lhs, rhs, tmp;
      bit        ok, wide;
      size_res_t res;
      sw = $signed(r.src_w);
      sh = $signed(r.src_h);
      bw = $signed(r.box_w);
      bh = $signed(r.box_h);
      ow = 0;
      oh = 0;
      ok = 1'b1;
      case (r.mode)
        MODE_RAW: begin
          ow = sw;
          oh = sh;
        end
        MODE_BOX: begin
          ow = bw;
          oh = bh;
        end
        MODE_WIDTH:  ok = scale_side(1'b1, sw, sh, bw, bh, ow, oh);
        MODE_HEIGHT: ok = scale_side(1'b0, sw, sh, bw, bh, ow, oh);
        MODE_INNER, MODE_OUTER: begin
          if (sw < 0) bw = -bw;
          if (sh < 0) bh = -bh;
          if (bw == 0 || bh == 0) begin
            ok = 1'b0;
          end else begin
            // The ratio test is done by cross products; opposite box signs flip it.
            lhs = sw * bh;
            rhs = sh * bw;
            if ((bw < 0) != (bh < 0)) begin
              tmp = lhs;
              lhs = rhs;
              rhs = tmp;
            end
            wide = (r.mode == MODE_INNER) ? (lhs > rhs) : (lhs < rhs);
            ok = scale_side(wide, sw, sh, bw, bh, ow, oh);
          end
        end
        MODE_WLIMIT: begin
          if (sw < bw) begin
            ow = sw;
            oh = sh;
          end else begin
            ok = scale_side(1'b1, sw, sh, bw, bh, ow, oh);
          end
        end
        MODE_HLIMIT: begin
          if (sh < bh) begin
            ow = sw;
            oh = sh;
          end else begin
            ok = scale_side(1'b0, sw, sh, bw, bh, ow, oh);
          end
        end
        MODE_LIMIT: begin
          if (sw > sh) begin
            if (sw < bw) begin
              ow = sw;
              oh = sh;
            end else begin
              ok = scale_side(1'b1, sw, sh, bw, bh, ow, oh);
            end
          end else begin
            if (sh < bh) begin
              ow = sw;
              oh = sh;
            end else begin
              ok = scale_side(1'b0, sw, sh, bw, bh, ow, oh);
            end
          end
        end
        default: begin
        end
      endcase
      if (!ok) begin
        ow = 0;
        oh = 0;
      end
      res.w    = OUT_BITS'(clip_out(ow));
      res.h    = OUT_BITS'(clip_out(oh));
      res.zdiv = !ok;
      return res;
    endfunction

    function void note_request(size_req_t r);
      mode_hits[r.mode]++;
      expected_sizes.push_back(fit_size(r));
    endfunction

    function void check_result(size_res_t got);
      size_res_t want;
      if (expected_sizes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with nothing expected: w=%0d h=%0d zero_divide=%0b",
                   $time, got.w, got.h, got.zdiv);
        return;
      end
      want = expected_sizes.pop_front();
      checked++;
      if (got.zdiv) zdiv_seen++;
      if (got.w !== want.w || got.h !== want.h || got.zdiv !== want.zdiv) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          if (got.w !== want.w)
            $display("%0t: out_w expected %0d, got %0d", $time, want.w, got.w);
          if (got.h !== want.h)
            $display("%0t: out_h expected %0d, got %0d", $time, want.h, got.h);
          if (got.zdiv !== want.zdiv)
            $display("%0t: zero_divide expected %0b, got %0b", $time, want.zdiv, got.zdiv);
        end else if (errors == MAX_REPORTS + 1) begin
          $display("%0t: further mismatches are counted but not listed", $time);
        end
      end
    endfunction

    function int pending();
      return expected_sizes.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  afs_in_if #(.SIZE_BITS(SIZE_BITS)) req_if ();
  afs_out_if                         res_if ();

  aspect_fit_size #(.SIZE_BITS(SIZE_BITS)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  fit_scoreboard sb;
  int            n_accepted;
  int            cycle_count;
  int            idle_pct;
  int            stall_pct;
  int            hold_left;
  bit            hold_done;

  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("FAIL aspect_fit_size");
      $finish;
    end
  end

  // Both channels are sampled at the rising edge; inputs only move at the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        sb.note_request('{req_if.mode, req_if.src_w, req_if.src_h,
                          req_if.box_w, req_if.box_h});
        n_accepted++;
      end
      if (res_if.valid && res_if.ready)
        sb.check_result('{res_if.out_w, res_if.out_h, res_if.zero_divide});
    end
  end

  // Result side: random stalls, plus one long hold-off that lets the pipeline fill up.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_req(size_req_t r);
    while ($urandom_range(99, 0) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.mode  <= r.mode;
    req_if.src_w <= r.src_w;
    req_if.src_h <= r.src_h;
    req_if.box_w <= r.box_w;
    req_if.box_h <= r.box_h;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic size_req_t mk(logic [MODE_BITS-1:0] m, longint sw, longint sh,
                                   longint bw, longint bh);
    size_req_t r;
    r.mode  = m;
    r.src_w = size_t'(sw);
    r.src_h = size_t'(sh);
    r.box_w = size_t'(bw);
    r.box_h = size_t'(bh);
    return r;
  endfunction

  // Full-range values are the largest share, with small (both signs), zero and extreme sizes mixed in.
  function automatic size_t rand_size();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: return size_t'($urandom());
      4, 5, 6:    return size_t'($urandom_range(1000, 1));
      7:          return size_t'(-longint'($urandom_range(1000, 1)));
      8:          return '0;
      default: begin
        case ($urandom_range(3, 0))
          0:       return size_t'(SIZE_MIN);
          1:       return size_t'(-1);
          2:       return size_t'(1);
          default: return size_t'(SIZE_MAX);
        endcase
      end
    endcase
  endfunction

  function automatic size_req_t random_req();
    size_req_t r;
    if ($urandom_range(99, 0) < 6)
      r.mode = MODE_BITS'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
    else
      r.mode = MODE_BITS'($urandom_range(MODE_LIMIT, MODE_RAW));
    r.src_w = rand_size();
    r.src_h = rand_size();
    r.box_w = rand_size();
    r.box_h = rand_size();
    // Equal ratios are rare at random, so force some ties for contain and cover.
    if ((r.mode == MODE_INNER || r.mode == MODE_OUTER) && $urandom_range(7, 0) == 0) begin
      r.box_w = r.src_w;
      r.box_h = r.src_h;
    end
    return r;
  endfunction

  task automatic run_directed();
    send_req(mk(MODE_RAW,    640, 480, SIZE_MIN, SIZE_MAX));
    send_req(mk(MODE_BOX,    SIZE_MIN, SIZE_MAX, SIZE_MIN, SIZE_MAX));
    send_req(mk(MODE_WIDTH,  1920, 1080, 1280, 0));
    send_req(mk(MODE_WIDTH,  0, 1080, 1280, 720));
    send_req(mk(MODE_WIDTH,  -3, 7, 5, 0));
    send_req(mk(MODE_HEIGHT, 1920, 1080, 0, 720));
    send_req(mk(MODE_HEIGHT, 100, 0, 50, 50));
    send_req(mk(MODE_INNER,  1920, 1080, 1280, 1280));
    send_req(mk(MODE_INNER,  1080, 1920, 1280, 1280));
    send_req(mk(MODE_INNER,  100, 100, 50, 50));
    send_req(mk(MODE_INNER,  -1920, 1080, 1280, 720));
    send_req(mk(MODE_INNER,  SIZE_MAX, SIZE_MIN, SIZE_MAX, SIZE_MIN));
    send_req(mk(MODE_INNER,  100, 100, 0, 50));
    send_req(mk(MODE_OUTER,  1920, 1080, 1280, 1280));
    send_req(mk(MODE_OUTER,  1920, -1080, 1280, 720));
    send_req(mk(MODE_OUTER,  100, 200, -50, 70));
    send_req(mk(MODE_OUTER,  100, -200, 50, 0));
    send_req(mk(MODE_WLIMIT, 100, 50, 200, 0));
    send_req(mk(MODE_WLIMIT, 400, 300, 200, 0));
    send_req(mk(MODE_WLIMIT, 0, 5, -10, 0));
    send_req(mk(MODE_HLIMIT, 100, 50, 0, 100));
    send_req(mk(MODE_HLIMIT, 300, 400, 0, 200));
    send_req(mk(MODE_HLIMIT, 5, 0, 0, -1));
    send_req(mk(MODE_LIMIT,  400, 300, 200, 200));
    send_req(mk(MODE_LIMIT,  SIZE_MIN, SIZE_MIN, SIZE_MIN, SIZE_MIN));
    send_req(mk(MODE_SPARE_LO, SIZE_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX));
    send_req(mk(MODE_SPARE_HI, SIZE_MIN, -1, SIZE_MIN, -1));
  endtask

  task automatic run_phase(int n, int send_idle, int recv_stall);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    repeat (n) send_req(random_req());
  endtask

  initial begin
    int spare;
    sb = new();
    req_if.valid = 1'b0;
    req_if.mode  = '0;
    req_if.src_w = '0;
    req_if.src_h = '0;
    req_if.box_w = '0;
    req_if.box_h = '0;
    res_if.ready = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();
    run_phase(PHASE_ITEMS, 0, 0);
    run_phase(PHASE_ITEMS, 50, 0);
    run_phase(PHASE_ITEMS, 0, 50);
    run_phase(PHASE_ITEMS - 20, 9, 9);
    req_if.valid <= 1'b0;

    while (sb.pending() != 0) @(negedge clk_i);
    repeat (2 * LATENCY) @(negedge clk_i);

    spare = 0;
    for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) spare += sb.mode_hits[m];
    $display("Covered %0d requests over all nine modes, %0d with unused mode codes, %0d %s",
             n_accepted, spare, sb.zdiv_seen, "zero-divide results.");
    $display("Checked %0d results under four idle patterns and one %0d-cycle hold-off.",
             sb.checked, HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS aspect_fit_size");
    end else begin
      $display("%0d mismatched results, %0d still expected", sb.errors, sb.pending());
      $display("FAIL aspect_fit_size");
    end
    $finish;
  end

endmodule

`default_nettype wire
